>>> rtl/assert_macros.svh
// Assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_SAME_CYCLE(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, cond, prop)
`endif

`endif

>>> rtl/pbsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pbsp_pkg;

  localparam int MAX_INDEL_LEN_DEF    = 1023;
  localparam int MAX_COLUMN_DEPTH_DEF = 32767;

  localparam int LEN_W   = 10;
  localparam int COUNT_W = 15;
  localparam int LEN_FIELD_MAX   = 1023;
  localparam int COUNT_FIELD_MAX = 32767;

  localparam int QUEUE_DEPTH = 4;

  // pileup syntax characters
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // upper-case letters; lower case differs only in bit 5
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_MAPQ   = 4'b0010,
    MODE_DIGITS = 4'b0100,
    MODE_SKIP   = 4'b1000
  } mode_t;

  // one queue entry: the results caused by one character
  typedef struct packed {
    logic               has_tok;
    logic [1:0]         code;
    logic               keep;
    logic               has_sum;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/pbsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pbsp_front import pbsp_pkg::*; #(
  parameter int MAX_INDEL_LEN    = MAX_INDEL_LEN_DEF,
  parameter int MAX_COLUMN_DEPTH = MAX_COLUMN_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] base_char,
  input  wire logic       column_end,
  output logic            push,
  output entry_t          push_data
);

  localparam logic [LEN_W-1:0] LenCap = LEN_W'(
    (MAX_INDEL_LEN < LEN_FIELD_MAX) ? MAX_INDEL_LEN : LEN_FIELD_MAX);
  localparam logic [COUNT_W-1:0] CountCap = COUNT_W'(
    (MAX_COLUMN_DEPTH < COUNT_FIELD_MAX) ? MAX_COLUMN_DEPTH : COUNT_FIELD_MAX);

  mode_t              mode_r, mode_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   skip_r, skip_nxt;
  logic [COUNT_W-1:0] kept_r, kept_nxt;

  logic               tok;
  logic               is_digit;
  logic [13:0]        len_acc;
  logic [LEN_W-1:0]   skip_dec;
  logic [LEN_W-1:0]   len_m1;
  logic               kept;
  logic [1:0]         code;

  assign is_digit = (base_char >= CH_ZERO) && (base_char <= CH_NINE);
  // digit value is the low nibble for '0'..'9'
  assign len_acc  = 14'(len_r) * 14'd10 + 14'(base_char[3:0]);
  assign skip_dec = (skip_r != '0) ? skip_r - LEN_W'(1) : skip_r;
  assign len_m1   = len_r - LEN_W'(1);

  always_comb begin
    kept = 1'b1;
    code = BASE_A;
    unique case (base_char & CASE_MASK)
      CH_A:    code = BASE_A;
      CH_C:    code = BASE_C;
      CH_G:    code = BASE_G;
      CH_T:    code = BASE_T;
      default: kept = 1'b0;
    endcase
  end

  always_comb begin
    tok      = 1'b0;
    mode_nxt = mode_r;
    len_nxt  = len_r;
    skip_nxt = skip_r;
    kept_nxt = kept_r;

    unique case (mode_r)
      MODE_MAPQ: mode_nxt = MODE_NORMAL;
      MODE_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) mode_nxt = MODE_NORMAL;
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          len_nxt = (len_acc > 14'(LenCap)) ? LenCap : len_acc[LEN_W-1:0];
        end else if (len_r == '0) begin
          mode_nxt = MODE_NORMAL;
          tok      = 1'b1;
        end else begin
          skip_nxt = len_m1;
          len_nxt  = '0;
          mode_nxt = (len_m1 != '0) ? MODE_SKIP : MODE_NORMAL;
        end
      end
      default: tok = 1'b1;
    endcase

    if (tok) begin
      case (base_char) inside
        CH_CARET: begin
          mode_nxt = MODE_MAPQ;
          tok      = 1'b0;
        end
        CH_DOLLAR: tok = 1'b0;
        CH_PLUS, CH_MINUS: begin
          mode_nxt = MODE_DIGITS;
          len_nxt  = '0;
          tok      = 1'b0;
        end
        default: ;
      endcase
    end

    if (tok && kept && (kept_r < CountCap)) kept_nxt = kept_r + COUNT_W'(1);

    push_data.has_tok = tok;
    push_data.code    = tok ? code : BASE_A;
    push_data.keep    = tok & kept;
    push_data.has_sum = column_end;
    push_data.count   = kept_nxt;
    push              = accept && (tok || column_end);

    // column end clears all parse state, unfinished syntax included
    if (column_end) begin
      mode_nxt = MODE_NORMAL;
      len_nxt  = '0;
      skip_nxt = '0;
      kept_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      len_r  <= '0;
      skip_r <= '0;
      kept_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      skip_r <= skip_nxt;
      kept_r <= kept_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pbsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pbsp_queue import pbsp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CntW'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CntW'(1);
    if (!push && pop) cnt_nxt = cnt_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

>>> rtl/pbsp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pbsp_back import pbsp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         head_valid,
  input  wire entry_t       head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_is_summary,
  output logic [1:0]        out_base_code,
  output logic              out_keep,
  output logic [COUNT_W-1:0] out_kept_count,
  output logic              out_last
);

  logic               valid_r;
  logic               tok_done_r, tok_done_nxt;
  logic               is_sum_r;
  logic [1:0]         code_r;
  logic               keep_r;
  logic [COUNT_W-1:0] count_r;
  logic               last_r;

  logic load;
  logic emit_tok;

  assign load     = !valid_r || !out_stall;
  // token beat goes first; summary follows from the same entry
  assign emit_tok = head.has_tok && !tok_done_r;
  assign pop      = load && head_valid && (!emit_tok || !head.has_sum);

  always_comb begin
    tok_done_nxt = tok_done_r;
    if (load && head_valid) tok_done_nxt = emit_tok && head.has_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      tok_done_r <= 1'b0;
    end else begin
      tok_done_r <= tok_done_nxt;
      if (load) valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (emit_tok) begin
        is_sum_r <= 1'b0;
        code_r   <= head.code;
        keep_r   <= head.keep;
        count_r  <= '0;
        last_r   <= 1'b0;
      end else begin
        is_sum_r <= 1'b1;
        code_r   <= BASE_A;
        keep_r   <= 1'b0;
        count_r  <= head.count;
        last_r   <= 1'b1;
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_is_summary = is_sum_r;
  assign out_base_code  = code_r;
  assign out_keep       = keep_r;
  assign out_kept_count = count_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

>>> rtl/pileup_base_string_parser.sv
// Results go through the queue, then the output register. Throughput: one
// character per cycle unless the queue is full; a character that ends a
// column and gives a token yields a token and a summary beat, so the result
// side sets the pace there (a four-entry queue absorbs short bursts).
// Reset: synchronous, active low; parse state, queue and output cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pileup_base_string_parser import pbsp_pkg::*; #(
  parameter int MAX_INDEL_LEN    = MAX_INDEL_LEN_DEF,
  parameter int MAX_COLUMN_DEPTH = MAX_COLUMN_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_base_char,
  input  wire logic               in_column_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_is_summary,
  output logic [1:0]              out_base_code,
  output logic                    out_keep,
  output logic [COUNT_W-1:0]      out_kept_count,
  output logic                    out_last
);

  logic   accept;
  logic   q_push, q_full, q_pop, q_head_valid;
  entry_t q_push_data, q_head;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  pbsp_front #(
    .MAX_INDEL_LEN    (MAX_INDEL_LEN),
    .MAX_COLUMN_DEPTH (MAX_COLUMN_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .base_char  (in_base_char),
    .column_end (in_column_end),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  pbsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  pbsp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_summary (out_is_summary),
    .out_base_code  (out_base_code),
    .out_keep       (out_keep),
    .out_kept_count (out_kept_count),
    .out_last       (out_last)
  );

  `ASSERT_SAME_CYCLE(a_no_push_full, clk, rst_n, q_full, !q_push)
  `ASSERT_SAME_CYCLE(a_pop_nonempty, clk, rst_n, q_pop, q_head_valid)
  `ASSERT_SAME_CYCLE(a_end_queued, clk, rst_n, accept && in_column_end, q_push)
  `ASSERT_NEXT_CYCLE(a_sum_last, clk, rst_n, q_pop && q_head.has_sum, out_valid && out_last)

endmodule
`default_nettype wire

>>> tb/pbsp_checker.sv
`timescale 1ns / 1ps
module pbsp_checker import pbsp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [7:0]         in_base_char,
  input  wire logic               in_column_end,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               out_is_summary,
  input  wire logic [1:0]         out_base_code,
  input  wire logic               out_keep,
  input  wire logic [COUNT_W-1:0] out_kept_count,
  input  wire logic               out_last,
  output int                      fail_count,
  output int                      pending
);

  localparam int LEN_CAP =
    (MAX_INDEL_LEN_DEF < LEN_FIELD_MAX) ? MAX_INDEL_LEN_DEF : LEN_FIELD_MAX;
  localparam int COUNT_CAP =
    (MAX_COLUMN_DEPTH_DEF < COUNT_FIELD_MAX) ? MAX_COLUMN_DEPTH_DEF : COUNT_FIELD_MAX;

  typedef struct packed {
    logic               is_summary;
    logic [1:0]         code;
    logic               keep;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  mode_t              mode;
  logic [LEN_W-1:0]   indel_len;
  logic [LEN_W-1:0]   skip_left;
  logic [COUNT_W-1:0] kept_total;
  result_t            results_due[$];

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
                             input logic [COUNT_W-1:0] want);
    if (got !== want) flag_error($sformatf("%s: got %0d, want %0d", name, got, want));
  endtask

  task automatic clear_parse();
    mode       = MODE_NORMAL;
    indel_len  = '0;
    skip_left  = '0;
    kept_total = '0;
  endtask

  task automatic queue_result(input result_t r);
    results_due = {results_due, r};
  endtask

  // works out the results of one character and queues them
  task automatic parse_char(input logic [7:0] ch, input logic col_end);
    logic       tok;
    logic       kept;
    logic [1:0] code;
    int         v;
    result_t    r;
    tok = 1'b0;
    case (mode)
      MODE_MAPQ: mode = MODE_NORMAL;
      MODE_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) mode = MODE_NORMAL;
      end
      MODE_DIGITS: begin
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          v = int'(indel_len) * 10 + int'(ch - CH_ZERO);
          indel_len = (v > LEN_CAP) ? LEN_W'(LEN_CAP) : LEN_W'(v);
        end else if (indel_len == 0) begin
          // mark with no digits: this char is an ordinary token
          mode = MODE_NORMAL;
          tok  = 1'b1;
        end else begin
          // this char is already the first indel char
          skip_left = indel_len - 1'b1;
          indel_len = '0;
          if (skip_left != 0) mode = MODE_SKIP;
          else mode = MODE_NORMAL;
        end
      end
      default: tok = 1'b1;
    endcase

    if (tok) begin
      if (ch == CH_CARET) begin
        mode = MODE_MAPQ;
        tok  = 1'b0;
      end else if (ch == CH_DOLLAR) begin
        tok = 1'b0;
      end else if (ch == CH_PLUS || ch == CH_MINUS) begin
        mode      = MODE_DIGITS;
        indel_len = '0;
        tok       = 1'b0;
      end
    end

    if (tok) begin
      kept = 1'b1;
      case (ch) inside
        "A", "a": code = BASE_A;
        "C", "c": code = BASE_C;
        "G", "g": code = BASE_G;
        "T", "t": code = BASE_T;
        default: begin
          code = BASE_A;
          kept = 1'b0;
        end
      endcase
      if (kept && kept_total < COUNT_CAP) kept_total++;
      r = '{is_summary: 1'b0, code: code, keep: kept, count: '0, last: 1'b0};
      queue_result(r);
    end

    if (col_end) begin
      r = '{is_summary: 1'b1, code: BASE_A, keep: 1'b0, count: kept_total, last: 1'b1};
      queue_result(r);
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_parse();
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          flag_error($sformatf("result beat with nothing expected (summary %0b, count %0d)",
                               out_is_summary, out_kept_count));
        end else begin
          want = results_due.pop_front();
          check_field("is_summary", COUNT_W'(out_is_summary), COUNT_W'(want.is_summary));
          check_field("base_code", COUNT_W'(out_base_code), COUNT_W'(want.code));
          check_field("keep", COUNT_W'(out_keep), COUNT_W'(want.keep));
          check_field("kept_count", out_kept_count, want.count);
          check_field("last", COUNT_W'(out_last), COUNT_W'(want.last));
        end
      end
      if (in_valid && !in_stall) parse_char(in_base_char, in_column_end);
    end
    pending = results_due.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pbsp_pkg::*;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic [7:0]         in_base_char  = '0;
  logic               in_column_end = 1'b0;
  logic               out_stall     = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               out_is_summary;
  logic [1:0]         out_base_code;
  logic               out_keep;
  logic [COUNT_W-1:0] out_kept_count;
  logic               out_last;

  int         fail_count;
  int         pending;
  int         chars_sent;
  int         calm_left;
  int         hold_asks;
  int         holds_done;
  logic [7:0] col_chars[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pileup_base_string_parser u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_base_char   (in_base_char),
    .in_column_end  (in_column_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_summary (out_is_summary),
    .out_base_code  (out_base_code),
    .out_keep       (out_keep),
    .out_kept_count (out_kept_count),
    .out_last       (out_last)
  );

  pbsp_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_base_char   (in_base_char),
    .in_column_end  (in_column_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_summary (out_is_summary),
    .out_base_code  (out_base_code),
    .out_keep       (out_keep),
    .out_kept_count (out_kept_count),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input logic [7:0] ch, input logic col_end);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(30, 120);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_base_char  <= ch;
    in_column_end <= col_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_str(input string s, input logic end_last);
    foreach (s[i]) send_beat(s[i], end_last && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic add_char(input logic [7:0] ch);
    col_chars = {col_chars, ch};
  endtask

  // one syntax element of a read-base string
  task automatic add_piece();
    string bases  = "ACGTacgt";
    string others = ".,*Nn";
    string digits;
    int    r;
    int    len;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      add_char(bases[$urandom_range(0, 7)]);
    end else if (r < 60) begin
      add_char(others[$urandom_range(0, 4)]);
    end else if (r < 70) begin
      add_char(CH_CARET);
      case ($urandom_range(0, 7))
        0:       add_char(CH_CARET);
        1:       add_char(CH_DOLLAR);
        2:       add_char(CH_PLUS);
        3:       add_char(CH_MINUS);
        4:       add_char(8'($urandom_range(0, 255)));
        default: add_char(8'($urandom_range(33, 126)));
      endcase
    end else if (r < 78) begin
      add_char(CH_DOLLAR);
    end else if (r < 92) begin
      add_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      if ($urandom_range(0, 9) == 0) return;
      if ($urandom_range(0, 19) == 0) len = 0;
      else if ($urandom_range(0, 19) == 0) len = $urandom_range(13, 400);
      else len = $urandom_range(1, 12);
      digits = $sformatf("%0d", len);
      if ($urandom_range(0, 9) == 0) digits = {"0", digits};
      foreach (digits[i]) add_char(digits[i]);
      // first indel char must not be a digit or it would extend the length
      if (len > 0) add_char(bases[$urandom_range(0, 7)]);
      for (int i = 1; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) add_char(8'($urandom_range(0, 255)));
        else add_char(bases[$urandom_range(0, 7)]);
      end
    end else begin
      add_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_column();
    int pieces;
    int keep_n;
    col_chars.delete();
    pieces = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    repeat (pieces) add_piece();
    // broken column: cut off, often in the middle of a mark
    if ($urandom_range(0, 9) == 0 && col_chars.size() > 1) begin
      keep_n = $urandom_range(1, col_chars.size() - 1);
      while (col_chars.size() > keep_n) void'(col_chars.pop_back());
    end
    foreach (col_chars[i]) send_beat(col_chars[i], i == col_chars.size() - 1);
  endtask

  // result side: random stalls, calm stretches and the requested long hold-offs
  initial begin : rx_side
    int n;
    forever begin
      if (holds_done != hold_asks) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : run_limit
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int  target;
    bit  held;
    bit  paused;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every base in both cases, dropped tokens, odd bytes, marks
    send_str("AaCcGgTt", 0);
    send_str(".,*N", 0);
    send_beat(8'hFF, 0);
    send_beat(8'h00, 0);
    send_beat(8'h80, 0);
    send_str("7", 0);
    send_str("^^$", 0);          // mapping quality that is itself a caret
    send_str("+2AC-G", 1);       // indel, then a bare minus before a token
    send_str("a+1", 1);          // column ends inside an indel length
    send_str("^", 1);            // column ends awaiting mapping quality
    send_str("+0T", 1);

    // saturated indel length, then 1023 dropped chars
    send_str("+99999", 0);
    send_str("G", 0);
    repeat (1022) send_beat(8'($urandom_range(0, 255)), 0);
    send_str("A", 1);

    target = 1950;
    held   = 1'b0;
    paused = 1'b0;
    while (chars_sent < target) begin
      if (!held && chars_sent > target - 1350) begin
        held = 1'b1;
        hold_asks++;
      end
      if (!paused && chars_sent > target - 700) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        wait_drained();
      end
      send_column();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
